// ===== rtl/wesch_pkg.sv =====
package wesch_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic REQ_SCHED = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_CMD = 1'b1;

  localparam logic [3:0] DAY_SUN       = 4'd0;
  localparam logic [3:0] DAY_MON       = 4'd1;
  localparam logic [3:0] DAY_FRI       = 4'd5;
  localparam logic [3:0] DAY_SAT       = 4'd6;
  localparam logic [3:0] RULE_EVERYDAY = 4'd7;
  localparam logic [3:0] RULE_WEEKDAY  = 4'd8;
  localparam logic [3:0] RULE_WEEKEND  = 4'd9;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  light_id;
    logic [3:0]  day;
    logic [10:0] minute_of_day;
    logic        turn_on;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic       accepted;
    logic [7:0] cmd_light;
    logic       cmd_on;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  light_id;
    logic [3:0]  day;
    logic [10:0] minute_of_day;
    logic        turn_on;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  typedef struct packed {
    logic                  shift;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_idx;
  } chain_ctrl_t;

  function automatic logic day_matches(input logic [3:0] rule, input logic [3:0] today);
    logic hit;
    hit = 1'b0;
    if (rule == RULE_EVERYDAY) begin
      hit = 1'b1;
    end else if (today <= DAY_SAT) begin
      if (rule == today) begin
        hit = 1'b1;
      end else if (rule == RULE_WEEKEND && (today == DAY_SUN || today == DAY_SAT)) begin
        hit = 1'b1;
      end else if (rule == RULE_WEEKDAY && today >= DAY_MON && today <= DAY_FRI) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/wesch_cell.sv =====
module wesch_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             wr_en,
  input  wesch_pkg::entry_t wr_entry,
  input  wesch_pkg::slot_t  nbr,
  output wesch_pkg::slot_t  q
);
  import wesch_pkg::*;

  logic   valid;
  entry_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= nbr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end else if (shift) begin
      entry <= nbr.entry;
    end
  end

  assign q = '{valid: valid, entry: entry};

endmodule

// ===== rtl/wesch_chain.sv =====
module wesch_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  wesch_pkg::chain_ctrl_t ctrl,
  input  wesch_pkg::entry_t      wr_entry,
  output wesch_pkg::slot_t       head
);
  import wesch_pkg::*;

  slot_t q [SLOT_COUNT];

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    logic wr_hit;
    assign wr_hit = ctrl.wr_en && (ctrl.wr_idx == SLOT_IDX_W'(i));
    wesch_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ctrl.shift),
      .wr_en    (wr_hit),
      .wr_entry (wr_entry),
      .nbr      (q[(i + 1) % SLOT_COUNT]),
      .q        (q[i])
    );
  end

  assign head = q[0];

endmodule

// ===== rtl/weekly_event_schedule_table.sv =====
// Schedule word: acknowledgement strobed in the cycle after accept; busy stays low.
// Tick word: busy while the slot ring rotates once past the head cell, one slot
// per cycle, and then through a flush state; commands come out one per matching
// slot, the last one marked. Result is not stallable.
// No new word is accepted until the tick is done.
// Synchronous reset frees every slot and returns the block to idle.
module weekly_event_schedule_table_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  wesch_pkg::req_t req,
  output logic            busy,
  output logic            result_valid,
  output wesch_pkg::rsp_t result
);
  import wesch_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      fill_count;
  logic [SLOT_IDX_W-1:0] scan_cnt;
  logic [3:0]            today;
  logic [10:0]           tick_minute;
  logic                  pend_valid;
  logic [7:0]            pend_light;
  logic                  pend_on;

  chain_ctrl_t ctrl;
  entry_t      wr_entry;
  slot_t       head;
  logic        accept;
  logic        has_room;
  logic        hit;

  assign accept   = start && !busy;
  assign has_room = fill_count < CNT_W'(SLOT_COUNT);
  assign busy     = (state != ST_IDLE);

  assign wr_entry = '{light_id: req.light_id, day: req.day,
                      minute_of_day: req.minute_of_day, turn_on: req.turn_on};

  always_comb begin
    ctrl.shift  = (state == ST_SCAN);
    ctrl.wr_en  = accept && (req.req_type == REQ_SCHED) && has_room;
    ctrl.wr_idx = fill_count[SLOT_IDX_W-1:0];
  end

  wesch_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .wr_entry (wr_entry),
    .head     (head)
  );

  assign hit = head.valid && day_matches(head.entry.day, today)
               && (head.entry.minute_of_day == tick_minute);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_count   <= '0;
      scan_cnt     <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_SCHED) begin
              result_valid <= 1'b1;
              if (has_room) begin
                fill_count <= fill_count + CNT_W'(1);
              end
            end else begin
              state      <= ST_SCAN;
              scan_cnt   <= '0;
              pend_valid <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            pend_valid <= 1'b1;
            if (pend_valid) begin
              result_valid <= 1'b1;
            end
          end
          scan_cnt <= scan_cnt + SLOT_IDX_W'(1);
          if (scan_cnt == SLOT_IDX_W'(SLOT_COUNT - 1)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          result_valid <= pend_valid;
          pend_valid   <= 1'b0;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.req_type == REQ_TICK) begin
      today       <= req.day;
      tick_minute <= req.minute_of_day;
    end
    if (state == ST_SCAN && hit) begin
      pend_light <= head.entry.light_id;
      pend_on    <= head.entry.turn_on;
    end
    case (state)
      ST_IDLE: begin
        result <= '{kind: KIND_ACK, accepted: has_room, cmd_light: 8'd0,
                    cmd_on: 1'b0, last: 1'b1};
      end
      ST_SCAN: begin
        result <= '{kind: KIND_CMD, accepted: 1'b0, cmd_light: pend_light,
                    cmd_on: pend_on, last: 1'b0};
      end
      ST_FLUSH: begin
        result <= '{kind: KIND_CMD, accepted: 1'b0, cmd_light: pend_light,
                    cmd_on: pend_on, last: 1'b1};
      end
      default: begin
        result <= '0;
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(SLOT_COUNT))
    else $error("fill count beyond slot count");

  a_ack_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_ACK |->
      $past(accept && req.req_type == REQ_SCHED))
    else $error("acknowledgement without schedule word");

  a_cmd_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_CMD |->
      ($past(state) == ST_SCAN || $past(state) == ST_FLUSH))
    else $error("command outside tick scan");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> $past(state) != ST_SCAN)
    else $error("last marked before scan end");

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> $past(scan_cnt) == SLOT_IDX_W'(SLOT_COUNT - 1))
    else $error("scan ended early");

endmodule
